>>> rtl/gvpc_pkg.sv
// Shared types and constants for the greedy viewport point cover block.
package gvpc_pkg;

   localparam int COORD_W = 12;
   localparam int LEVEL_W = 10;
   localparam int KEY_W   = LEVEL_W + 2 * COORD_W;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT  = 2'd3;

   localparam logic [CSR_W-1:0] VIEW_WIDTH_RST  = 12'd80;
   localparam logic [CSR_W-1:0] VIEW_HEIGHT_RST = 12'd25;
   localparam logic [CSR_W-1:0] MAP_WIDTH_RST   = 12'd192;
   localparam logic [CSR_W-1:0] MAP_HEIGHT_RST  = 12'd192;

   typedef enum logic [15:0] {
      ST_IDLE      = 16'h0001,
      ST_SRCH_RD   = 16'h0002,
      ST_SRCH_CMP  = 16'h0004,
      ST_DECIDE    = 16'h0008,
      ST_SHIFT_RD  = 16'h0010,
      ST_SHIFT_WR  = 16'h0020,
      ST_INSERT    = 16'h0040,
      ST_POST      = 16'h0080,
      ST_SEED_RD   = 16'h0100,
      ST_SEED_CHK  = 16'h0200,
      ST_EMIT_MID  = 16'h0400,
      ST_BOX       = 16'h0800,
      ST_COVER_RD  = 16'h1000,
      ST_COVER_CMP = 16'h2000,
      ST_NEXT      = 16'h4000,
      ST_EMIT_LAST = 16'h8000
   } state_type;

endpackage

>>> rtl/greedy_viewport_point_cover.sv
// Greedy viewport point cover: sorted point store and box planner.
//
//  channel | direction | handshake                   | payload
//  req     | in        | req_valid / req_ready       | point_x, point_y, point_z, last_point
//  rsp     | out       | rsp_valid / rsp_ready       | box_x, box_y, box_z, box_valid,
//          |           |                             | last_box, points_dropped
//  csr     | in        | csr_write_en                | csr_index, csr_wdata
//
// A point entering the store goes through a linear search of the store (one write port,
// one registered read port) and a shift of the tail.
// The plan walks the store once per uncovered seed, from the entry after the seed until
// the z level changes or the store ends; each box waits for a free result register.
// Reset is synchronous and clears the count, the flags and the covered bits; the store
// contents need no reset. req_ready is high only while idle; a stalled rsp holds the plan.
module greedy_viewport_point_cover
   import gvpc_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [12:0]      req_point_x,
   input  logic signed [12:0]      req_point_y,
   input  logic signed [10:0]      req_point_z,
   input  logic                    req_last_point,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [COORD_W-1:0]      rsp_box_x,
   output logic [COORD_W-1:0]      rsp_box_y,
   output logic [LEVEL_W-1:0]      rsp_box_z,
   output logic                    rsp_box_valid,
   output logic                    rsp_last_box,
   output logic                    rsp_points_dropped,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   state_type state_ff, state_in;

   logic [CSR_W-1:0] view_width_ff, view_height_ff, map_width_ff, map_height_ff;

   logic [KEY_W-1:0]  store_ff [MAX_POINTS];
   logic [KEY_W-1:0]  rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [KEY_W-1:0]  mem_wdata;

   logic [KEY_W-1:0]  key_ff, key_in;
   logic              last_ff, last_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  seed_ff, seed_in;
   logic [MAX_POINTS-1:0] covered_ff, covered_in;

   logic [COORD_W-1:0] pend_x_ff, pend_x_in;
   logic [COORD_W-1:0] pend_y_ff, pend_y_in;
   logic [LEVEL_W-1:0] pend_z_ff, pend_z_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               pend_have_ff, pend_have_in;
   logic [COORD_W:0]   x_end_ff, x_end_in;
   logic [COORD_W:0]   y_end_ff, y_end_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic [LEVEL_W-1:0] rsp_z_ff, rsp_z_in;
   logic               rsp_bv_ff, rsp_bv_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_drop_ff, rsp_drop_in;

   // request decode
   logic             req_ok;
   logic [KEY_W-1:0] req_key;
   assign req_ok  = !req_point_x[12] && !req_point_y[12] && !req_point_z[10];
   assign req_key = {req_point_z[LEVEL_W-1:0], req_point_y[COORD_W-1:0],
                     req_point_x[COORD_W-1:0]};

   // box arithmetic, from the seed entry in the read register
   logic [CSR_W-1:0]    vw_eff, vh_eff;
   logic [COORD_W-1:0]  rd_x, rd_y;
   logic [LEVEL_W-1:0]  rd_z;
   logic signed [12:0]  vx, vy, lim_x, lim_y, lim_xc, lim_yc, cx, cy, cx2, cy2;
   logic [COORD_W-1:0]  bx, by;
   logic                in_box;
   logic [CNT_W-1:0]    idx_nxt, seed_nxt;
   logic                out_free;

   assign vw_eff = (view_width_ff == '0)  ? CSR_W'(1) : view_width_ff;
   assign vh_eff = (view_height_ff == '0) ? CSR_W'(1) : view_height_ff;
   assign rd_x = rd_data_ff[COORD_W-1:0];
   assign rd_y = rd_data_ff[2*COORD_W-1:COORD_W];
   assign rd_z = rd_data_ff[KEY_W-1:2*COORD_W];

   always_comb begin
      vx = $signed({1'b0, rd_x}) - $signed({2'b00, vw_eff[CSR_W-1:1]});
      vy = $signed({1'b0, rd_y}) - $signed({2'b00, vh_eff[CSR_W-1:1]});
      lim_x = $signed({1'b0, map_width_ff}) - $signed({1'b0, vw_eff});
      lim_y = $signed({1'b0, map_height_ff}) - $signed({1'b0, vh_eff});
      lim_xc = (lim_x < 0) ? 13'sd0 : lim_x;
      lim_yc = (lim_y < 0) ? 13'sd0 : lim_y;
      cx = (vx > lim_xc) ? lim_xc : vx;
      cy = (vy > lim_yc) ? lim_yc : vy;
      cx2 = (cx < 0) ? 13'sd0 : cx;
      cy2 = (cy < 0) ? 13'sd0 : cy;
      bx = cx2[COORD_W-1:0];
      by = cy2[COORD_W-1:0];
   end

   assign in_box = ({1'b0, rd_x} >= {1'b0, pend_x_ff}) && ({1'b0, rd_x} < x_end_ff) &&
                   ({1'b0, rd_y} >= {1'b0, pend_y_ff}) && ({1'b0, rd_y} < y_end_ff);
   assign idx_nxt  = idx_ff + CNT_W'(1);
   assign seed_nxt = seed_ff + CNT_W'(1);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      seed_in       = seed_ff;
      covered_in    = covered_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_z_in     = pend_z_ff;
      pend_valid_in = pend_valid_ff;
      pend_have_in  = pend_have_ff;
      x_end_in      = x_end_ff;
      y_end_in      = y_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_bv_in     = rsp_bv_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_drop_in   = rsp_drop_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff[ADDR_W-1:0];
      mem_wdata     = key_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in  = req_key;
               last_in = req_last_point;
               if (!req_ok) begin
                  state_in = ST_POST;
               end else if (count_ff == '0) begin
                  pos_in   = '0;
                  state_in = ST_DECIDE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            priority if (rd_data_ff == key_ff) begin
               // duplicate: drop, even with a full store
               state_in = ST_POST;
            end else if (rd_data_ff > key_ff) begin
               pos_in   = idx_ff;
               state_in = ST_DECIDE;
            end else if (idx_nxt == count_ff) begin
               pos_in   = count_ff;
               state_in = ST_DECIDE;
            end else begin
               idx_in   = idx_nxt;
               state_in = ST_SRCH_RD;
            end
         end
         ST_DECIDE: begin
            priority if (count_ff == CNT_MAX) begin
               ovf_in   = 1'b1;
               state_in = ST_POST;
            end else if (pos_ff == count_ff) begin
               state_in = ST_INSERT;
            end else begin
               idx_in   = count_ff - CNT_W'(1);
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            // move the tail up one slot, top entry first
            mem_we    = 1'b1;
            mem_waddr = idx_nxt[ADDR_W-1:0];
            mem_wdata = rd_data_ff;
            if (idx_ff == pos_ff) begin
               state_in = ST_INSERT;
            end else begin
               idx_in   = idx_ff - CNT_W'(1);
               state_in = ST_SHIFT_RD;
            end
         end
         ST_INSERT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[ADDR_W-1:0];
            mem_wdata = key_ff;
            count_in  = count_ff + CNT_W'(1);
            state_in  = ST_POST;
         end
         ST_POST: begin
            priority if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (count_ff == '0) begin
               pend_x_in     = '0;
               pend_y_in     = '0;
               pend_z_in     = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_EMIT_LAST;
            end else begin
               seed_in  = '0;
               idx_in   = '0;
               state_in = ST_SEED_RD;
            end
         end
         ST_SEED_RD: begin
            if (covered_ff[idx_ff[ADDR_W-1:0]]) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_SEED_CHK;
            end
         end
         ST_SEED_CHK: begin
            // a new seed means the previous box was not the last one
            state_in = pend_have_ff ? ST_EMIT_MID : ST_BOX;
         end
         ST_EMIT_MID: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pend_x_ff;
               rsp_y_in     = pend_y_ff;
               rsp_z_in     = pend_z_ff;
               rsp_bv_in    = pend_valid_ff;
               rsp_last_in  = 1'b0;
               rsp_drop_in  = ovf_ff;
               state_in     = ST_BOX;
            end
         end
         ST_BOX: begin
            pend_x_in     = bx;
            pend_y_in     = by;
            pend_z_in     = rd_z;
            pend_valid_in = 1'b1;
            pend_have_in  = 1'b1;
            x_end_in      = {1'b0, bx} + {1'b0, vw_eff};
            y_end_in      = {1'b0, by} + {1'b0, vh_eff};
            idx_in        = idx_nxt;
            state_in      = ST_COVER_RD;
         end
         ST_COVER_RD: begin
            state_in = (idx_ff == count_ff) ? ST_NEXT : ST_COVER_CMP;
         end
         ST_COVER_CMP: begin
            // store is sorted by z: stop at the first entry off this level
            if (rd_z != pend_z_ff) begin
               state_in = ST_NEXT;
            end else begin
               if (in_box) begin
                  covered_in[idx_ff[ADDR_W-1:0]] = 1'b1;
               end
               idx_in   = idx_nxt;
               state_in = ST_COVER_RD;
            end
         end
         ST_NEXT: begin
            seed_in  = seed_nxt;
            idx_in   = seed_nxt;
            state_in = (seed_nxt == count_ff) ? ST_EMIT_LAST : ST_SEED_RD;
         end
         ST_EMIT_LAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pend_x_ff;
               rsp_y_in     = pend_y_ff;
               rsp_z_in     = pend_z_ff;
               rsp_bv_in    = pend_valid_ff;
               rsp_last_in  = 1'b1;
               rsp_drop_in  = ovf_ff;
               count_in     = '0;
               ovf_in       = 1'b0;
               covered_in   = '0;
               pend_have_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // point store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_ff[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         covered_ff     <= '0;
         pend_have_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         view_width_ff  <= VIEW_WIDTH_RST;
         view_height_ff <= VIEW_HEIGHT_RST;
         map_width_ff   <= MAP_WIDTH_RST;
         map_height_ff  <= MAP_HEIGHT_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         covered_ff   <= covered_in;
         pend_have_ff <= pend_have_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_VIEW_WIDTH:  view_width_ff  <= csr_wdata;
               CSR_VIEW_HEIGHT: view_height_ff <= csr_wdata;
               CSR_MAP_WIDTH:   map_width_ff   <= csr_wdata;
               CSR_MAP_HEIGHT:  map_height_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      seed_ff       <= seed_in;
      pend_x_ff     <= pend_x_in;
      pend_y_ff     <= pend_y_in;
      pend_z_ff     <= pend_z_in;
      pend_valid_ff <= pend_valid_in;
      x_end_ff      <= x_end_in;
      y_end_ff      <= y_end_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
      rsp_bv_ff     <= rsp_bv_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_box_x          = rsp_x_ff;
   assign rsp_box_y          = rsp_y_ff;
   assign rsp_box_z          = rsp_z_ff;
   assign rsp_box_valid      = rsp_bv_ff;
   assign rsp_last_box       = rsp_last_ff;
   assign rsp_points_dropped = rsp_drop_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("point count above store depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CNT_MAX))
      else $error("overflow flagged with room left in store");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!pend_have_ff && (covered_ff == '0)))
      else $error("plan state left over while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("request accepted without leaving idle");

endmodule
